@@ sv/srtf_pkg.sv @@
// Shared types for the shortest-remaining-time-first scheduler.
`default_nettype none

package srtf_pkg;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
    } t_in_item;

    typedef struct packed {
        logic [31:0] tick_time;
        logic        running_valid;
        logic [3:0]  running_slot;
        logic        started;
        logic        preempted;
        logic [3:0]  preempted_slot;
        logic        finished;
        logic [31:0] completion_time;
        logic [31:0] turnaround_time;
        logic [31:0] waiting_time;
        logic        all_done;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_UPDATE = 2'd3
    } t_state;

    typedef struct packed {
        logic add_wr;
        logic tick_start;
        logic scan_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic loaded_zero;
        logic scan_last;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/srtf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/srtf_ctrl.sv @@
// Sequencer for the scheduler: add, scan, drain and update phases.
`default_nettype none

module srtf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_op,
    input  wire srtf_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output srtf_pkg::t_cmd     o_cmd
);

    srtf_pkg::t_state r_state;
    srtf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srtf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srtf_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_op == srtf_pkg::OP_TICK) begin
                    n_state = i_sts.loaded_zero ? srtf_pkg::ST_UPDATE : srtf_pkg::ST_SCAN;
                end
            end
            srtf_pkg::ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = srtf_pkg::ST_DRAIN;
                end
            end
            srtf_pkg::ST_DRAIN: begin
                n_state = srtf_pkg::ST_UPDATE;
            end
            srtf_pkg::ST_UPDATE: begin
                if (!i_sts.out_busy) begin
                    n_state = srtf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            srtf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.add_wr     = (i_in_op == srtf_pkg::OP_ADD);
                    o_cmd.tick_start = (i_in_op == srtf_pkg::OP_TICK);
                end
            end
            srtf_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            srtf_pkg::ST_DRAIN: begin
            end
            srtf_pkg::ST_UPDATE: begin
                o_cmd.update = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/srtf_dp.sv @@
// Datapath: process table, minimum search, counters and result register.
`default_nettype none

module srtf_dp #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire srtf_pkg::t_in_item i_in,
    input  wire srtf_pkg::t_cmd     i_cmd,
    input  wire logic               i_out_ready,
    output srtf_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    output srtf_pkg::t_out_item     o_out
);

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    logic [CW-1:0]         r_loaded;
    logic [CW-1:0]         r_completed;
    logic [31:0]           r_time;
    logic                  r_prev_vld;
    logic [AW-1:0]         r_prev_slot;
    logic [AW-1:0]         r_scan_idx;
    logic                  r_eval_vld;
    logic [AW-1:0]         r_eval_idx;
    logic                  r_found;
    logic [AW-1:0]         r_pick;
    logic [BURST_BITS-1:0] r_best;
    logic [15:0]           r_best_arr;
    logic [BURST_BITS-1:0] r_best_bur;
    logic                  r_out_vld;
    srtf_pkg::t_out_item   r_out;
    srtf_pkg::t_out_item   n_out;

    logic [BURST_BITS-1:0] bur_in;
    logic                  add_ok;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [BURST_BITS-1:0] rem_wdata;
    logic [15:0]           arr_rd;
    logic [BURST_BITS-1:0] bur_rd;
    logic [BURST_BITS-1:0] rem_rd;
    logic                  cand;
    logic                  take;
    logic [BURST_BITS-1:0] rem_next;
    logic                  fin;
    logic [CW-1:0]         completed_next;
    logic [AW+3:0]         pick_ext;
    logic [AW+3:0]         prev_ext;
    logic [BURST_BITS+31:0] bur_ext;
    logic [31:0]           ct;
    logic [31:0]           tat;

    generate
        if (BURST_BITS <= 16) begin : g_bur_trunc
            assign bur_in = i_in.burst_time[BURST_BITS-1:0];
        end else begin : g_bur_ext
            assign bur_in = {{(BURST_BITS-16){1'b0}}, i_in.burst_time};
        end
    endgenerate

    assign add_ok    = i_cmd.add_wr && (r_loaded < CW'(MAX_PROCS)) && (bur_in != '0);
    assign rem_next  = r_best - BURST_BITS'(1);
    assign fin       = r_found && (rem_next == '0);
    assign we        = add_ok || (i_cmd.update && r_found);
    assign waddr     = add_ok ? r_loaded[AW-1:0] : r_pick;
    assign rem_wdata = add_ok ? bur_in : rem_next;

    srtf_ram #(.WIDTH(16), .DEPTH(MAX_PROCS)) u_arr_ram (
        .i_clk   (i_clk),
        .i_we    (add_ok),
        .i_waddr (waddr),
        .i_wdata (i_in.arrival_time),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_idx),
        .o_rdata (arr_rd)
    );

    srtf_ram #(.WIDTH(BURST_BITS), .DEPTH(MAX_PROCS)) u_bur_ram (
        .i_clk   (i_clk),
        .i_we    (add_ok),
        .i_waddr (waddr),
        .i_wdata (bur_in),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_idx),
        .o_rdata (bur_rd)
    );

    srtf_ram #(.WIDTH(BURST_BITS), .DEPTH(MAX_PROCS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (rem_wdata),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_scan_idx),
        .o_rdata (rem_rd)
    );

    // Entry is a candidate once arrived and not yet run to completion.
    assign cand = r_eval_vld && ({16'b0, arr_rd} <= r_time) && (rem_rd != '0);
    assign take = cand && (!r_found || rem_rd < r_best);

    assign o_sts.loaded_zero = (r_loaded == '0);
    assign o_sts.scan_last   = (CW'(r_scan_idx) + CW'(1) == r_loaded);
    assign o_sts.out_busy    = r_out_vld && !i_out_ready;

    assign completed_next = r_completed + CW'(fin);
    assign pick_ext       = {4'b0, r_pick};
    assign prev_ext       = {4'b0, r_prev_slot};
    assign bur_ext        = {32'b0, r_best_bur};
    assign ct             = r_time + 32'd1;
    assign tat            = ct - {16'b0, r_best_arr};

    always_comb begin
        n_out                = '0;
        n_out.tick_time      = r_time;
        n_out.running_valid  = r_found;
        n_out.all_done       = (completed_next == r_loaded);
        if (r_found) begin
            n_out.running_slot = pick_ext[3:0];
            n_out.started      = !r_prev_vld;
            if (r_prev_vld && r_prev_slot != r_pick) begin
                n_out.preempted      = 1'b1;
                n_out.preempted_slot = prev_ext[3:0];
            end
            if (fin) begin
                n_out.finished        = 1'b1;
                n_out.completion_time = ct;
                n_out.turnaround_time = tat;
                n_out.waiting_time    = tat - bur_ext[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_completed <= '0;
            r_time      <= '0;
            r_prev_vld  <= 1'b0;
            r_prev_slot <= '0;
            r_scan_idx  <= '0;
            r_eval_vld  <= 1'b0;
            r_found     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.scan_step;
            if (add_ok) begin
                r_loaded <= r_loaded + CW'(1);
            end
            if (i_cmd.tick_start) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + AW'(1);
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.update) begin
                r_time      <= ct;
                r_completed <= completed_next;
                if (r_found) begin
                    r_prev_vld  <= !fin;
                    r_prev_slot <= fin ? '0 : r_pick;
                end
            end
            if (i_cmd.update) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_eval_idx <= r_scan_idx;
        if (take) begin
            r_best     <= rem_rd;
            r_pick     <= r_eval_idx;
            r_best_arr <= arr_rd;
            r_best_bur <= bur_rd;
        end
        if (i_cmd.update) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ sv/srtf_preemptive_scheduler.sv @@
// Top level of the preemptive shortest-remaining-time-first scheduler.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries add and tick
// beats. An add stores arrival and burst in the next free slot and gives no
// result; adds to a full table or with zero burst are dropped.
// A tick scans the table one slot per cycle through the registered read port
// of the slot memories: a scan step per loaded slot, a drain step to evaluate
// the last read, then a write-back step that loads the result register (an
// empty table goes straight to write-back).
// Input ready returns with the result, so a new tick is not taken before the
// last one is through; adds can be taken every cycle while no tick is running.
// Output channel (o_out_valid / i_out_ready, payload o_out) holds one result
// beat in a register. Adds are still taken while a result waits; a tick
// whose result is ready holds in its write-back step until the previous
// result beat has been taken.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the time
// counter and drops any pending result; slot contents are not cleared and
// are never read before being written.
`default_nettype none

module srtf_preemptive_scheduler #(
    parameter int MAX_PROCS  = 16,
    parameter int BURST_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire srtf_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output srtf_pkg::t_out_item      o_out
);

    srtf_pkg::t_cmd cmd;
    srtf_pkg::t_sts sts;

    srtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in.operation),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    srtf_dp #(
        .MAX_PROCS  (MAX_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // A tick beat blocks further input while its scan runs.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.operation == srtf_pkg::OP_TICK) |=> !o_in_ready)
        else $error("input taken right after a tick beat");

    // A result beat only appears out of tick processing.
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a tick in progress");

    a_start_xor_preempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.started && o_out.preempted))
        else $error("started and preempted both set");

endmodule

`default_nettype wire
